// ===== rtl/obd_rs_pkg.sv =====
// Shared types and constants of the OBD request scheduler.
`timescale 1ns / 1ps
package obd_rs_pkg;
	localparam int PendSlotsDef = 8;
	localparam int SubSlotsDef = 8;
	localparam logic [1:0] MODE_REQ = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;
	localparam logic [1:0] MODE_UNSUB = 2'd2;
	localparam logic [1:0] MODE_TICK = 2'd3;
	localparam logic [2:0] KIND_SEND = 3'd0;
	localparam logic [2:0] KIND_MATCH = 3'd1;
	localparam logic [2:0] KIND_TIMEOUT = 3'd2;
	localparam logic [2:0] KIND_FULL = 3'd3;
	localparam logic [2:0] KIND_DONE = 3'd4;
	localparam logic [7:0] SERVICE_ANSWER = 8'h41;
	localparam logic [10:0] IDENT_RESET = 11'h7E8;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam logic CFG_IDENT = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] pid;
		logic [2:0] slot;
		logic from_sub;
		logic [31:0] payload;
		logic [31:0] dropped;
		logic last;
	} result_t;
endpackage

// ===== rtl/obd_rs_outreg.sv =====
// Output register stage holding one result transaction.
`timescale 1ns / 1ps
module obd_rs_outreg (
	input logic clk,
	input logic arst_n,
	input logic push,
	input obd_rs_pkg::result_t din,
	output logic full,
	output logic out_valid,
	input logic out_ready,
	output obd_rs_pkg::result_t dout
);
	import obd_rs_pkg::*;
	logic valid_q;
	result_t data_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= din;
		end
	end
	assign full = valid_q && !out_ready;
	assign out_valid = valid_q;
	assign dout = data_q;
	property p_push_free;
		@(posedge clk) disable iff (!arst_n) push |-> !full;
	endproperty
	a_push_free: assert property (p_push_free) else $error("push into held result");
	property p_hold;
		@(posedge clk) disable iff (!arst_n) (valid_q && !out_ready) |=> valid_q;
	endproperty
	a_hold: assert property (p_hold) else $error("result lost");
	property p_data;
		@(posedge clk) disable iff (!arst_n) (valid_q && !out_ready) |=> $stable(data_q);
	endproperty
	a_data: assert property (p_data) else $error("held result changed");
endmodule

// ===== rtl/obd_request_scheduler.sv =====
// Top level of the OBD request scheduler: sequencer over pending and subscription memories.
`timescale 1ns / 1ps
// channel | direction | handshake           | payload
// input   | in        | in_valid / in_ready | mode pid period_ms now_ms frame_*
// result  | out       | out_valid/out_ready | kind out_pid slot from_subscription ...
// config  | in        | cfg_we              | cfg_index cfg_data
//
// One transaction at a time; in_ready is high only in idle.
// Request: request, then done. Subscribe: a search over the subscription slots (it stops
// on a matching entry), a write, then done. Unsubscribe: a walk over every subscription
// slot, then done. Tick: read and fire for each subscription, read and drop for each pending
// slot, an answer search over the pending slots that stops on a match, then done and idle.
// Each result waits in the output register; the sequencer stalls in the states that push a
// result while a result is held there with out_ready low.
// Reset empties both tables (flag vectors in flops) and the drop count; the timing
// memory is not cleared.
module obd_request_scheduler #(
	parameter int PENDING_SLOTS = obd_rs_pkg::PendSlotsDef,
	parameter int SUB_SLOTS = obd_rs_pkg::SubSlotsDef
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] mode,
	input logic [7:0] pid,
	input logic [31:0] period_ms,
	input logic [31:0] now_ms,
	input logic frame_valid,
	input logic [10:0] frame_ident,
	input logic [7:0] frame_service,
	input logic [7:0] frame_pid,
	input logic [31:0] frame_payload,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] kind,
	output logic [7:0] out_pid,
	output logic [2:0] slot,
	output logic from_subscription,
	output logic [31:0] answer_payload,
	output logic [31:0] dropped_total,
	output logic last,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data
);
	import obd_rs_pkg::*;
	localparam int PW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
	localparam int SW = (SUB_SLOTS > 1) ? $clog2(SUB_SLOTS) : 1;
	localparam int PC = PW + 1;
	localparam int SC = SW + 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_REQ = 4'd1;
	localparam logic [3:0] ST_SUBF = 4'd2;
	localparam logic [3:0] ST_SUBW = 4'd3;
	localparam logic [3:0] ST_UNSUB = 4'd4;
	localparam logic [3:0] ST_FIRE_RD = 4'd5;
	localparam logic [3:0] ST_FIRE = 4'd6;
	localparam logic [3:0] ST_TO_RD = 4'd7;
	localparam logic [3:0] ST_TO = 4'd8;
	localparam logic [3:0] ST_MATCH = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	// flags in flops; wide fields in memories
	logic [PENDING_SLOTS-1:0] pv_q;
	logic [7:0] ppid_q [PENDING_SLOTS];
	logic [PENDING_SLOTS-1:0] pfs_q;
	logic [SW-1:0] psi_q [PENDING_SLOTS];
	logic [31:0] psent_mem [PENDING_SLOTS];
	logic [SUB_SLOTS-1:0] sv_q, saw_q, sfn_q;
	logic [7:0] spid_q [SUB_SLOTS];
	// interval in the upper half, last send time in the lower half
	logic [63:0] stime_mem [SUB_SLOTS];

	logic [10:0] ident_q;
	logic [15:0] timeout_q;
	logic [31:0] drop_q;
	logic [3:0] state_q;
	logic [PC-1:0] pi_q;
	logic [SC-1:0] si_q;
	logic [SC-1:0] found_q;
	logic [7:0] pid_q;
	logic [31:0] int_q, now_q, pay_q;
	logic fmatch_q;
	logic [31:0] rd_sent_s1;
	logic [63:0] rd_time_s1;

	logic push;
	result_t res, dout;
	logic full;

	// lowest free pending slot: small priority encoder on the valid vector
	logic have_free;
	logic [PW-1:0] free_idx;
	always_comb begin
		have_free = 1'b0;
		free_idx = '0;
		for (int i = PENDING_SLOTS - 1; i >= 0; i--) begin
			if (!pv_q[i]) begin
				have_free = 1'b1;
				free_idx = PW'(i);
			end
		end
	end

	logic [PW-1:0] pi;
	logic [SW-1:0] si;
	assign pi = pi_q[PW-1:0];
	assign si = si_q[SW-1:0];

	// synchronous memory reads
	always_ff @(posedge clk) begin
		rd_sent_s1 <= psent_mem[pi];
		rd_time_s1 <= stime_mem[si];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q <= IDENT_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_IDENT) begin
				ident_q <= cfg_data[10:0];
			end else begin
				timeout_q <= cfg_data;
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	logic due;
	logic [31:0] age;
	assign due = sfn_q[si] || ((now_q - rd_time_s1[31:0]) >= rd_time_s1[63:32]);
	assign age = now_q - rd_sent_s1;

	logic sub_last, pend_last;
	assign sub_last = (si_q == SC'(SUB_SLOTS - 1));
	assign pend_last = (pi_q == PC'(PENDING_SLOTS - 1));

	logic [SW-1:0] rel_idx;
	assign rel_idx = psi_q[pi];

	always_comb begin
		push = 1'b0;
		res = '0;
		res.dropped = drop_q;
		case (state_q)
			ST_REQ: begin
				push = !full;
				res.pid = pid_q;
				res.kind = have_free ? KIND_SEND : KIND_FULL;
				res.slot = have_free ? 3'(free_idx) : 3'd0;
			end
			ST_FIRE: begin
				push = !full && sv_q[si] && !saw_q[si] && due && have_free;
				res.kind = KIND_SEND;
				res.pid = spid_q[si];
				res.slot = 3'(free_idx);
				res.from_sub = 1'b1;
			end
			ST_TO: begin
				push = !full && pv_q[pi] && (age > {16'd0, timeout_q});
				res.kind = KIND_TIMEOUT;
				res.pid = ppid_q[pi];
				res.slot = 3'(pi);
				res.from_sub = pfs_q[pi];
				res.dropped = drop_q + 32'd1;
			end
			ST_MATCH: begin
				push = !full && fmatch_q && pv_q[pi] && (ppid_q[pi] == pid_q);
				res.kind = KIND_MATCH;
				res.pid = ppid_q[pi];
				res.slot = 3'(pi);
				res.from_sub = pfs_q[pi];
				res.payload = pay_q;
			end
			ST_DONE: begin
				push = !full;
				res.kind = KIND_DONE;
				res.last = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// memory writes; a fire keeps the interval it has just read
	always_ff @(posedge clk) begin
		if (state_q == ST_REQ && !full && have_free) begin
			psent_mem[free_idx] <= now_q;
		end
		if (state_q == ST_FIRE && push) begin
			psent_mem[free_idx] <= now_q;
			stime_mem[si] <= {rd_time_s1[63:32], now_q};
		end
		if (state_q == ST_SUBW && found_q != SC'(SUB_SLOTS)) begin
			stime_mem[found_q[SW-1:0]] <= {int_q, 32'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pv_q <= '0;
			pfs_q <= '0;
			sv_q <= '0;
			saw_q <= '0;
			sfn_q <= '0;
			drop_q <= '0;
			pi_q <= '0;
			si_q <= '0;
			found_q <= '0;
			fmatch_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pi_q <= '0;
						si_q <= '0;
						found_q <= SC'(SUB_SLOTS);
						fmatch_q <= frame_valid && (frame_ident == ident_q)
							&& (frame_service == SERVICE_ANSWER);
						case (mode)
							MODE_REQ: state_q <= ST_REQ;
							MODE_SUB: state_q <= ST_SUBF;
							MODE_UNSUB: state_q <= ST_UNSUB;
							default: state_q <= ST_FIRE_RD;
						endcase
					end
				end
				ST_REQ: begin
					if (!full) begin
						if (have_free) begin
							pv_q[free_idx] <= 1'b1;
							pfs_q[free_idx] <= 1'b0;
						end
						state_q <= ST_DONE;
					end
				end
				ST_SUBF: begin
					// pass 1: existing entry, then first free
					if (sv_q[si] && spid_q[si] == pid_q) begin
						found_q <= si_q;
						state_q <= ST_SUBW;
					end else if (!sv_q[si] && found_q == SC'(SUB_SLOTS)) begin
						found_q <= si_q;
					end
					if (!(sv_q[si] && spid_q[si] == pid_q)) begin
						if (sub_last) begin
							state_q <= ST_SUBW;
						end else begin
							si_q <= si_q + SC'(1);
						end
					end
				end
				ST_SUBW: begin
					state_q <= ST_DONE;
					if (found_q != SC'(SUB_SLOTS)) begin
						sv_q[found_q[SW-1:0]] <= 1'b1;
						saw_q[found_q[SW-1:0]] <= 1'b0;
						sfn_q[found_q[SW-1:0]] <= 1'b1;
					end
				end
				ST_UNSUB: begin
					if (spid_q[si] == pid_q) begin
						sv_q[si] <= 1'b0;
					end
					if (sub_last) begin
						state_q <= ST_DONE;
					end else begin
						si_q <= si_q + SC'(1);
					end
				end
				ST_FIRE_RD: begin
					state_q <= ST_FIRE;
				end
				ST_FIRE: begin
					if (!full) begin
						if (push) begin
							sfn_q[si] <= 1'b0;
							saw_q[si] <= 1'b1;
							pv_q[free_idx] <= 1'b1;
							pfs_q[free_idx] <= 1'b1;
						end
						if (sub_last) begin
							state_q <= ST_TO_RD;
						end else begin
							si_q <= si_q + SC'(1);
							state_q <= ST_FIRE_RD;
						end
					end
				end
				ST_TO_RD: begin
					state_q <= ST_TO;
				end
				ST_TO: begin
					if (!full) begin
						if (push) begin
							drop_q <= drop_q + 32'd1;
							pv_q[pi] <= 1'b0;
							if (pfs_q[pi] && sv_q[rel_idx]) begin
								saw_q[rel_idx] <= 1'b0;
							end
						end
						if (pend_last) begin
							pi_q <= '0;
							state_q <= ST_MATCH;
						end else begin
							pi_q <= pi_q + PC'(1);
							state_q <= ST_TO_RD;
						end
					end
				end
				ST_MATCH: begin
					if (!full) begin
						if (push) begin
							pv_q[pi] <= 1'b0;
							if (pfs_q[pi] && sv_q[rel_idx]) begin
								saw_q[rel_idx] <= 1'b0;
							end
							state_q <= ST_DONE;
						end else if (!fmatch_q || pend_last) begin
							state_q <= ST_DONE;
						end else begin
							pi_q <= pi_q + PC'(1);
						end
					end
				end
				ST_DONE: begin
					if (!full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers for the current item
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			pid_q <= (mode == MODE_TICK) ? frame_pid : pid;
			int_q <= period_ms;
			now_q <= now_ms;
			pay_q <= frame_payload;
		end
		if (state_q == ST_REQ && !full && have_free) begin
			ppid_q[free_idx] <= pid_q;
			psi_q[free_idx] <= '0;
		end
		if (state_q == ST_FIRE && push) begin
			ppid_q[free_idx] <= spid_q[si];
			psi_q[free_idx] <= si;
		end
		if (state_q == ST_SUBW && found_q != SC'(SUB_SLOTS)) begin
			spid_q[found_q[SW-1:0]] <= pid_q;
		end
	end

	obd_rs_outreg u_out (
		.clk(clk), .arst_n(arst_n), .push(push), .din(res), .full(full),
		.out_valid(out_valid), .out_ready(out_ready), .dout(dout)
	);
	assign kind = dout.kind;
	assign out_pid = dout.pid;
	assign slot = dout.slot;
	assign from_subscription = dout.from_sub;
	assign answer_payload = dout.payload;
	assign dropped_total = dout.dropped;
	assign last = dout.last;

	property p_one_item;
		@(posedge clk) disable iff (!arst_n) (in_valid && in_ready) |=> !in_ready;
	endproperty
	a_one_item: assert property (p_one_item) else $error("second item taken");
	property p_done_idle;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_DONE && !full) |=> (state_q == ST_IDLE);
	endproperty
	a_done_idle: assert property (p_done_idle) else $error("done did not finish");
	property p_drop;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_TO && push) |=> (drop_q == $past(drop_q) + 32'd1);
	endproperty
	a_drop: assert property (p_drop) else $error("drop count slip");
endmodule
